@@ hw/rtl/rcq_pkg.sv @@
// ----------------------------------------------------------------------------
// Range count query package
// Shared constants, request kinds and the query token that walks the cells.
// ----------------------------------------------------------------------------
package rcq_pkg;

   localparam int MAX_POINTS = 1024;

   // Width of the held-point count (must hold MAX_POINTS itself)
   localparam int COUNT_W = $clog2(MAX_POINTS + 1);
   localparam int POINT_W = 32;
   localparam int RESULT_W = 11;

   localparam int REQ_DATA_W = 3 * POINT_W;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;

   typedef enum logic [REQ_USER_W-1:0] {
      MODE_CLEAR = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_QUERY = 2'd2
   } mode_type;

   // Partial count travelling down the cell row
   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] count;
   } token_type;

endpackage

@@ hw/rtl/rcq_cell.sv @@
// ----------------------------------------------------------------------------
// Range count cell
// Holds one point, shifts it on to its neighbour on a load and adds its own
// hit to the query token as the token passes through.
// ----------------------------------------------------------------------------
module rcq_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              shift_en,
   input  logic                              occupied,
   input  logic signed [rcq_pkg::POINT_W-1:0] point_prev,
   output logic signed [rcq_pkg::POINT_W-1:0] point_out,
   input  logic signed [rcq_pkg::POINT_W-1:0] range_low,
   input  logic signed [rcq_pkg::POINT_W-1:0] range_high,
   input  rcq_pkg::token_type                tok_in,
   output rcq_pkg::token_type                tok_out
);

   logic signed [rcq_pkg::POINT_W-1:0] point_ff;
   logic signed [rcq_pkg::POINT_W-1:0] point_in;
   logic                               tok_valid_ff;
   logic                               tok_valid_in;
   logic [rcq_pkg::COUNT_W-1:0]        tok_count_ff;
   logic [rcq_pkg::COUNT_W-1:0]        tok_count_in;
   logic                               hit;

   // Reversed bounds fail one of the two compares, so no extra check
   assign hit = occupied && (point_ff >= range_low) && (point_ff <= range_high);

   always_comb begin
      point_in     = shift_en ? point_prev : point_ff;
      tok_valid_in = advance ? tok_in.valid : tok_valid_ff;
      tok_count_in = advance ? (tok_in.count + rcq_pkg::COUNT_W'(hit)) : tok_count_ff;
   end

   always_ff @(posedge clock) begin
      point_ff     <= point_in;
      tok_count_ff <= tok_count_in;
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
      end
   end

   assign point_out     = point_ff;
   assign tok_out.valid = tok_valid_ff;
   assign tok_out.count = tok_count_ff;

endmodule

@@ hw/rtl/range_count_over_point_set.sv @@
// ----------------------------------------------------------------------------
// Range count over point set
// Row of MAX_POINTS cells holding the point set; a query token walks the row
// one cell per cycle while the output is free and counts held points in range.
// ----------------------------------------------------------------------------
// Clear and load requests produce no response. A query token passes start_ff
// and every cell of the row in turn before its count enters the output register;
// one query is in the row at a time and the next request is taken once its
// result reaches the output register, so no request is taken while a query
// is in flight. Reset empties the point set and drops any query in flight;
// the stored point values themselves are left as they are.
module range_count_over_point_set (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] point_value, [63:32] range_low, [95:64] range_high
   input  logic [rcq_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] mode
   input  logic [rcq_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [10:0] points_in_range
   output logic [rcq_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int PW = rcq_pkg::POINT_W;
   localparam int NP = rcq_pkg::MAX_POINTS;

   logic signed [PW-1:0]         req_point;
   logic signed [PW-1:0]         req_low;
   logic signed [PW-1:0]         req_high;
   rcq_pkg::mode_type            req_mode;
   logic                         accept;

   logic [rcq_pkg::COUNT_W-1:0]  held_ff;
   logic [rcq_pkg::COUNT_W-1:0]  held_in;
   logic signed [PW-1:0]         low_ff;
   logic signed [PW-1:0]         low_in;
   logic signed [PW-1:0]         high_ff;
   logic signed [PW-1:0]         high_in;
   logic                         busy_ff;
   logic                         busy_in;
   logic                         start_ff;
   logic                         start_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [rcq_pkg::RESULT_W-1:0] rsp_count_ff;
   logic [rcq_pkg::RESULT_W-1:0] rsp_count_in;

   logic                         advance;
   logic                         shift_en;
   rcq_pkg::token_type           head_tok;
   rcq_pkg::token_type           tail_tok;
   rcq_pkg::token_type           tok_chain   [NP];
   logic signed [PW-1:0]         point_chain [NP];

   assign req_point = req_tdata[PW-1:0];
   assign req_low   = req_tdata[2*PW-1:PW];
   assign req_high  = req_tdata[3*PW-1:2*PW];
   assign req_mode  = rcq_pkg::mode_type'(req_tuser);

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;

   assign tail_tok = tok_chain[NP-1];
   // Hold the whole row while a finished count waits for a full output
   assign advance  = !(tail_tok.valid && rsp_valid_ff && !rsp_tready);
   assign shift_en = accept && (req_mode == rcq_pkg::MODE_LOAD) &&
                     (held_ff < rcq_pkg::COUNT_W'(NP));

   assign head_tok.valid = start_ff;
   assign head_tok.count = '0;

   always_comb begin
      held_in      = held_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      busy_in      = busy_ff;
      start_in     = start_ff && !advance;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;

      if (accept) begin
         case (req_mode)
            rcq_pkg::MODE_CLEAR: begin
               held_in = '0;
            end
            rcq_pkg::MODE_LOAD: begin
               if (shift_en) begin
                  held_in = held_ff + 1'b1;
               end
            end
            rcq_pkg::MODE_QUERY: begin
               low_in   = req_low;
               high_in  = req_high;
               busy_in  = 1'b1;
               start_in = 1'b1;
            end
            default: begin
               // unused kind: drop
            end
         endcase
      end

      if (tail_tok.valid && advance) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = rcq_pkg::RESULT_W'(tail_tok.count);
         busy_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      low_ff       <= low_in;
      high_ff      <= high_in;
      rsp_count_ff <= rsp_count_in;
      if (reset) begin
         held_ff      <= '0;
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Newest point enters cell 0, so cells below the held count are occupied
   for (genvar gi = 0; gi < NP; gi++) begin : g_cell
      logic                 occupied;
      logic signed [PW-1:0] point_prev;
      rcq_pkg::token_type   tok_prev;

      assign occupied = rcq_pkg::COUNT_W'(gi) < held_ff;

      if (gi == 0) begin : g_head
         assign point_prev = req_point;
         assign tok_prev   = head_tok;
      end else begin : g_body
         assign point_prev = point_chain[gi-1];
         assign tok_prev   = tok_chain[gi-1];
      end

      rcq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .shift_en   (shift_en),
         .occupied   (occupied),
         .point_prev (point_prev),
         .point_out  (point_chain[gi]),
         .range_low  (low_ff),
         .range_high (high_ff),
         .tok_in     (tok_prev),
         .tok_out    (tok_chain[gi])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rcq_pkg::RSP_DATA_W'(rsp_count_ff);

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= rcq_pkg::COUNT_W'(NP))
      else $error("held count above capacity");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == rcq_pkg::MODE_CLEAR) |=> (held_ff == '0))
      else $error("clear did not empty the set");

   a_tail_busy: assert property (@(posedge clock) disable iff (reset)
      tail_tok.valid |-> busy_ff)
      else $error("token at tail with no query in flight");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (busy_ff && !req_tready))
      else $error("query start without busy");

   a_no_shift_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> $stable(held_ff))
      else $error("point set changed during a query");

endmodule

@@ tb/sv/range_count_over_point_set_tb.sv @@
// ----------------------------------------------------------------------------
// Range count over point set testbench
// Drives clear, load and query requests into the point-set block with random
// gaps on both channels. It keeps a shadow copy of the point set, predicts
// every query count and compares each response against the oldest prediction.
// A directed table covers the extremes first. Random episodes of clears,
// loads and queries follow, one of them filling the store past its capacity.
// ----------------------------------------------------------------------------
module range_count_over_point_set_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_POINTS = rcq_pkg::MAX_POINTS;
   localparam int POINT_W = rcq_pkg::POINT_W;
   localparam int RESULT_W = rcq_pkg::RESULT_W;
   localparam int REQ_DATA_W = rcq_pkg::REQ_DATA_W;
   localparam int REQ_USER_W = rcq_pkg::REQ_USER_W;
   localparam int RSP_DATA_W = rcq_pkg::RSP_DATA_W;

   localparam int CLOCK_PERIOD = 10;
   localparam int RANDOM_ITEMS = 1150;
   localparam int FILL_AFTER = 150;
   localparam int QUERY_LATENCY = MAX_POINTS + 2;
   localparam int DRAIN_CYCLES = 2 * QUERY_LATENCY;
   localparam int WATCHDOG_LIMIT = 8 * QUERY_LATENCY;
   localparam int NUM_DIRECTED = 21;

   localparam logic [REQ_USER_W-1:0] MODE_UNUSED = 2'd3;

   localparam logic signed [POINT_W-1:0] P_MIN = 32'sh8000_0000;
   localparam logic signed [POINT_W-1:0] P_MAX = 32'sh7fff_ffff;
   localparam logic signed [POINT_W-1:0] P_ONES = -32'sd1;
   localparam logic signed [POINT_W-1:0] P_ZERO = 32'sd0;

   typedef struct packed {
      logic [REQ_USER_W-1:0]     mode;
      logic signed [POINT_W-1:0] point_value;
      logic signed [POINT_W-1:0] range_low;
      logic signed [POINT_W-1:0] range_high;
      logic                      typed;
      logic [RESULT_W-1:0]       typed_count;
   } req_item_type;

   // Fixed answers only where they follow from the set at a glance
   localparam req_item_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{rcq_pkg::MODE_QUERY, P_ZERO,  P_MIN,   P_MAX,   1'b1, 11'd0},
      '{rcq_pkg::MODE_LOAD,  P_MIN,   P_ZERO,  P_ZERO,  1'b0, 11'd0},
      '{rcq_pkg::MODE_LOAD,  P_MAX,   P_ZERO,  P_ZERO,  1'b0, 11'd0},
      '{rcq_pkg::MODE_LOAD,  P_ZERO,  P_ZERO,  P_ZERO,  1'b0, 11'd0},
      '{rcq_pkg::MODE_LOAD,  P_ONES,  P_ZERO,  P_ZERO,  1'b0, 11'd0},
      '{rcq_pkg::MODE_QUERY, P_ZERO,  P_MIN,   P_MAX,   1'b1, 11'd4},
      '{rcq_pkg::MODE_QUERY, P_ZERO,  P_MIN,   P_MIN,   1'b1, 11'd1},
      '{rcq_pkg::MODE_QUERY, P_ZERO,  P_MAX,   P_MAX,   1'b1, 11'd1},
      '{rcq_pkg::MODE_QUERY, P_ZERO,  P_MAX,   P_MIN,   1'b1, 11'd0},
      '{rcq_pkg::MODE_QUERY, P_ZERO,  P_ZERO,  P_ONES,  1'b1, 11'd0},
      '{rcq_pkg::MODE_QUERY, P_ZERO,  P_ONES,  P_ZERO,  1'b1, 11'd2},
      '{MODE_UNUSED,         P_ONES,  P_ONES,  P_ONES,  1'b0, 11'd0},
      '{rcq_pkg::MODE_QUERY, P_ZERO,  P_MIN,   P_MAX,   1'b1, 11'd4},
      '{rcq_pkg::MODE_LOAD,  32'sd5,  P_ONES,  P_ONES,  1'b0, 11'd0},
      '{rcq_pkg::MODE_QUERY, P_ONES,  32'sd1,  32'sd10, 1'b0, 11'd0},
      '{rcq_pkg::MODE_CLEAR, P_ONES,  P_ONES,  P_ONES,  1'b0, 11'd0},
      '{rcq_pkg::MODE_QUERY, P_ZERO,  P_MIN,   P_MAX,   1'b1, 11'd0},
      '{rcq_pkg::MODE_LOAD,  32'sd7,  P_ZERO,  P_ZERO,  1'b0, 11'd0},
      '{rcq_pkg::MODE_QUERY, P_ZERO,  32'sd7,  32'sd7,  1'b1, 11'd1},
      '{MODE_UNUSED,         P_ZERO,  P_ZERO,  P_ZERO,  1'b0, 11'd0},
      '{rcq_pkg::MODE_QUERY, P_ZERO,  32'sd8,  32'sd6,  1'b1, 11'd0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [31:0] point_value, [63:32] range_low, [95:64] range_high
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // [1:0] mode
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [10:0] points_in_range
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Shadow copy of the point set
   logic signed [POINT_W-1:0] shadow_points [MAX_POINTS];
   int unsigned               shadow_held = 0;

   logic [RESULT_W-1:0] expected_counts [$];
   logic [RESULT_W-1:0] count_head;

   bit          no_stall = 1'b0;
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned random_items = 0;
   int unsigned n_clear = 0, n_load = 0, n_query = 0, n_unused = 0;
   int unsigned n_dropped = 0, peak_held = 0, counts_checked = 0;

   range_count_over_point_set uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Update the shadow set; returns 1 with the count when the request is a query
   function automatic bit track_point_set(input req_item_type item,
                                          output logic [RESULT_W-1:0] count);
      int unsigned hits;
      hits = 0;
      count = '0;
      case (item.mode)
         rcq_pkg::MODE_CLEAR: begin
            shadow_held = 0;
         end
         rcq_pkg::MODE_LOAD: begin
            if (shadow_held < MAX_POINTS) begin
               shadow_points[shadow_held] = item.point_value;
               shadow_held++;
               if (shadow_held > peak_held) peak_held = shadow_held;
            end else begin
               n_dropped++;
            end
         end
         rcq_pkg::MODE_QUERY: begin
            if ($signed(item.range_low) <= $signed(item.range_high)) begin
               for (int i = 0; i < shadow_held; i++) begin
                  if ($signed(shadow_points[i]) >= $signed(item.range_low) &&
                      $signed(shadow_points[i]) <= $signed(item.range_high))
                     hits++;
               end
            end
            count = hits[RESULT_W-1:0];
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // Cluster four in ten points near zero so that queries see non-trivial counts
   function automatic logic signed [POINT_W-1:0] random_point();
      case ($urandom_range(9))
         0: return P_MIN;
         1: return P_MAX;
         2: return P_MIN + $urandom_range(3);
         3: return P_MAX - $urandom_range(3);
         4, 5: return $urandom;
         default: return $urandom_range(40) - 20;
      endcase
   endfunction

   // Bounds sit on or next to a held point half of the time
   function automatic logic signed [POINT_W-1:0] random_bound();
      if (shadow_held != 0 && $urandom_range(1) == 1)
         return shadow_points[$urandom_range(shadow_held - 1)] + $urandom_range(2) - 1;
      return random_point();
   endfunction

   function automatic req_item_type make_item(input logic [REQ_USER_W-1:0] mode);
      req_item_type item;
      logic signed [POINT_W-1:0] swap;
      item.mode = mode;
      item.point_value = $urandom;
      item.range_low = $urandom;
      item.range_high = $urandom;
      item.typed = 1'b0;
      item.typed_count = '0;
      if (mode == rcq_pkg::MODE_LOAD) item.point_value = random_point();
      if (mode == rcq_pkg::MODE_QUERY) begin
         item.range_low = random_bound();
         item.range_high = random_bound();
         // keep most bounds in order, leave the rest reversed
         if ($urandom_range(3) != 0 && $signed(item.range_low) > $signed(item.range_high)) begin
            swap = item.range_low;
            item.range_low = item.range_high;
            item.range_high = swap;
         end
         if ($urandom_range(15) == 0) begin
            item.range_low = P_MIN;
            item.range_high = P_MAX;
         end
      end
      return item;
   endfunction

   task automatic send_request(input req_item_type item);
      int unsigned         gap;
      bit                  gives_count;
      logic [RESULT_W-1:0] predicted;
      gap = 0;
      if (!no_stall) begin
         while ($urandom_range(99) < 20) gap++;
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= item.mode;
      req_tdata <= {item.range_high, item.range_low, item.point_value};
      do @(posedge clock); while (!req_tready);
      case (item.mode)
         rcq_pkg::MODE_CLEAR: n_clear++;
         rcq_pkg::MODE_LOAD: n_load++;
         rcq_pkg::MODE_QUERY: n_query++;
         default: n_unused++;
      endcase
      gives_count = track_point_set(item, predicted);
      if (gives_count) expected_counts.push_back(item.typed ? item.typed_count : predicted);
   endtask

   // Random request of the given kind, sometimes preceded by an unused-mode one
   task automatic issue(input logic [REQ_USER_W-1:0] mode);
      if ($urandom_range(19) == 0) begin
         send_request(make_item(MODE_UNUSED));
         random_items++;
      end
      send_request(make_item(mode));
      random_items++;
   endtask

   initial begin
      req_item_type item;
      int unsigned  steps;
      bit           filled;
      filled = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_DIRECTED; r++) send_request(DIRECTED_ROWS[r]);

      while (random_items < RANDOM_ITEMS) begin
         if (!filled && random_items >= FILL_AFTER) begin
            // fill the store, push past capacity, then query the full set
            filled = 1'b1;
            issue(rcq_pkg::MODE_CLEAR);
            while (shadow_held < MAX_POINTS) begin
               no_stall = (shadow_held >= 200 && shadow_held < 600);
               issue(rcq_pkg::MODE_LOAD);
            end
            no_stall = 1'b0;
            repeat ($urandom_range(2, 6)) issue(rcq_pkg::MODE_LOAD);
            item = make_item(rcq_pkg::MODE_QUERY);
            item.range_low = P_MIN;
            item.range_high = P_MAX;
            send_request(item);
            random_items++;
            repeat (5) issue(rcq_pkg::MODE_QUERY);
         end else begin
            if ($urandom_range(9) < 7) issue(rcq_pkg::MODE_CLEAR);
            steps = ($urandom_range(7) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 24);
            repeat (steps)
               issue(($urandom_range(3) == 0) ? rcq_pkg::MODE_QUERY : rcq_pkg::MODE_LOAD);
            repeat ($urandom_range(1, 3)) issue(rcq_pkg::MODE_QUERY);
         end
      end
      req_tvalid <= 1'b0;

      while (expected_counts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_counts.size() != 0) begin
         $error("points_in_range: %0d responses missing", expected_counts.size());
         error_count++;
      end

      $display("Sent %0d clears, %0d loads, %0d queries and %0d unused-mode requests.",
               n_clear, n_load, n_query, n_unused);
      $display("Checked %0d counts; peak occupancy %0d, %0d loads dropped on a full store.",
               counts_checked, peak_held, n_dropped);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Check each response against the oldest prediction, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_counts.size() == 0) begin
            $error("points_in_range: expected no response, got %0d",
                   rsp_tdata[RESULT_W-1:0]);
            error_count++;
         end else begin
            count_head = expected_counts.pop_front();
            counts_checked++;
            if (rsp_tdata[RESULT_W-1:0] !== count_head) begin
               $error("points_in_range: expected %0d, got %0d",
                      count_head, rsp_tdata[RESULT_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[RSP_DATA_W-1:RESULT_W] !== '0) begin
               $error("rsp_tdata padding: expected 0, got %0h",
                      rsp_tdata[RSP_DATA_W-1:RESULT_W]);
               error_count++;
            end
         end
      end
      rsp_tready <= no_stall || ($urandom_range(99) >= 20);
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
